FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the fixed-point ALU.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define FPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hdl/fpa_pkg.sv
// Package for the fixed-point ALU: command codes, result record and
// saturation helpers. Depends on nothing.
package fpa_pkg;

	localparam int FRAC_BITS_DEF = 8;

	typedef enum logic [3:0] {
		CMD_ADD      = 4'd0,
		CMD_SUB      = 4'd1,
		CMD_MUL      = 4'd2,
		CMD_DIV      = 4'd3,
		CMD_EQ       = 4'd4,
		CMD_NE       = 4'd5,
		CMD_LT       = 4'd6,
		CMD_GT       = 4'd7,
		CMD_LE       = 4'd8,
		CMD_GE       = 4'd9,
		CMD_MIN      = 4'd10,
		CMD_MAX      = 4'd11,
		CMD_INC      = 4'd12,
		CMD_DEC      = 4'd13,
		CMD_FROM_INT = 4'd14,
		CMD_TO_INT   = 4'd15
	} cmd_t;

	// A clamped 32-bit value and its saturation flag.
	typedef struct packed {
		logic [31:0] value;
		logic        sat;
	} val_t;

	// Result record carried along the divider chain.
	typedef struct packed {
		logic [31:0] value;
		logic        cmp;
		logic        sat;
		logic        dz;
		logic        is_div;
		logic        neg;
	} res_t;

	// Clamps a signed 64-bit value to the 32-bit range.
	function automatic val_t clamp_s64(input logic signed [63:0] v);
		val_t r;
		r.sat = 1'b0;
		r.value = v[31:0];
		if (v > $signed(64'h0000_0000_7FFF_FFFF)) begin
			r.sat = 1'b1;
			r.value = 32'h7FFF_FFFF;
		end else if (v < $signed(64'hFFFF_FFFF_8000_0000)) begin
			r.sat = 1'b1;
			r.value = 32'h8000_0000;
		end
		return r;
	endfunction

	// Rebuilds a signed value from sign and magnitude, then clamps it.
	function automatic val_t from_mag(input logic neg, input logic [63:0] mag);
		val_t r;
		logic [63:0] negm;
		negm = ~mag + 64'd1;
		r.sat = 1'b0;
		if (neg) begin
			if (mag > 64'h0000_0000_8000_0000) begin
				r.sat = 1'b1;
				r.value = 32'h8000_0000;
			end else begin
				r.value = negm[31:0];
			end
		end else begin
			if (mag > 64'h0000_0000_7FFF_FFFF) begin
				r.sat = 1'b1;
				r.value = 32'h7FFF_FFFF;
			end else begin
				r.value = mag[31:0];
			end
		end
		return r;
	endfunction

endpackage

FILE: hdl/fixed_point_alu.sv
// Top level of the signed fixed-point ALU with FRAC_BITS fraction bits.
// Depends on fpa_pkg, fpa_front, fpa_div_cell, fpa_back and assert_macros.svh.
//
// Usage:
// The input channel (in_valid, in_stall) carries one beat of command,
// operand_a and operand_b; the output channel (out_valid, out_stall) carries
// one beat of result_value, compare_true, saturated and divide_by_zero.
// A beat moves at a rising edge where valid is high and stall is low.
// Every command takes the same path: an operand and product register, a
// result and setup register, a chain of 32 + FRAC_BITS division cells that
// each develop one quotient bit, and an output register. One beat is
// accepted per cycle while in_stall is low.
// Each stage holds its beat while the next stage is full and stalled, so
// empty stages still fill while the receiver stalls; in_stall rises only
// once every stage holds a beat. Reset clears all valid flags; the block
// then accepts at once.
`include "assert_macros.svh"
module fixed_point_alu #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [3:0]          command,
	input  logic signed [31:0]  operand_a,
	input  logic signed [31:0]  operand_b,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  result_value,
	output logic                compare_true,
	output logic                saturated,
	output logic                divide_by_zero
);

	localparam int NQ = 32 + FRAC_BITS;

	logic           lk_valid [NQ+1];
	logic           lk_ready [NQ+1];
	fpa_pkg::res_t  lk_res [NQ+1];
	logic [NQ-1:0]  lk_nq [NQ+1];
	logic [31:0]    lk_rem [NQ+1];
	logic [31:0]    lk_d [NQ+1];
	logic           front_ready;

	assign in_stall = !front_ready;
	assign lk_rem[0] = '0;

	// Operand register, product and non-divide results.
	fpa_front #(.FRAC_BITS(FRAC_BITS), .NQ(NQ)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(front_ready),
		.command(command), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(lk_valid[0]), .out_ready(lk_ready[0]),
		.out_res(lk_res[0]), .out_nq(lk_nq[0]), .out_d(lk_d[0])
	);

	// Division chain, one quotient bit per cell.
	for (genvar i = 0; i < NQ; i++) begin : g_cell
		fpa_div_cell #(.NQ(NQ)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(lk_valid[i]), .in_ready(lk_ready[i]),
			.in_res(lk_res[i]), .in_nq(lk_nq[i]),
			.in_rem(lk_rem[i]), .in_d(lk_d[i]),
			.out_valid(lk_valid[i+1]), .out_ready(lk_ready[i+1]),
			.out_res(lk_res[i+1]), .out_nq(lk_nq[i+1]),
			.out_rem(lk_rem[i+1]), .out_d(lk_d[i+1])
		);
	end

	// Rounding, clamping and the output register.
	fpa_back #(.NQ(NQ)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(lk_valid[NQ]), .in_ready(lk_ready[NQ]),
		.in_res(lk_res[NQ]), .in_nq(lk_nq[NQ]),
		.in_rem(lk_rem[NQ]), .in_d(lk_d[NQ]),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .compare_true(compare_true),
		.saturated(saturated), .divide_by_zero(divide_by_zero)
	);

	// A divide by zero gives a zero, unclamped result.
	`FPA_ASSERT_IMP(a_dz_zero, out_valid && divide_by_zero, result_value == 32'sd0 && !saturated, "divide by zero result not zero")
	// Comparisons give a zero, unclamped result.
	`FPA_ASSERT_IMP(a_cmp_zero, out_valid && compare_true, result_value == 32'sd0 && !saturated && !divide_by_zero, "comparison result not clean")
	// A clamped result sits at one end of the 32-bit range.
	`FPA_ASSERT_IMP(a_sat_end, out_valid && saturated, result_value == 32'sh7FFF_FFFF || result_value == 32'sh8000_0000, "saturated result not at a limit")

endmodule

FILE: hdl/fpa_front.sv
// Front stages of the fixed-point ALU: operand register with the product,
// then all non-divide results and the divider setup. Uses fpa_pkg.
module fpa_front #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
	parameter int NQ = 32 + FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0]          command,
	input  logic signed [31:0]  operand_a,
	input  logic signed [31:0]  operand_b,
	output logic                out_valid,
	input  logic                out_ready,
	output fpa_pkg::res_t       out_res,
	output logic [NQ-1:0]       out_nq,
	output logic [31:0]         out_d
);

	logic                v_s1, v_s2;
	logic                en_s1, en_s2;
	fpa_pkg::cmd_t       cmd_s1;
	logic signed [31:0]  a_s1, b_s1;
	logic signed [63:0]  prod_s1;
	fpa_pkg::res_t       res_s2;
	logic [NQ-1:0]       nq_s2;
	logic [31:0]         d_s2;

	assign en_s1 = !v_s1 || en_s2;
	assign en_s2 = !v_s2 || out_ready;
	assign in_ready = en_s1;

	// Stage one registers the operands and their full product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			cmd_s1 <= fpa_pkg::cmd_t'(command);
			a_s1 <= operand_a;
			b_s1 <= operand_b;
			prod_s1 <= 64'(operand_a) * 64'(operand_b);
		end
	end

	logic signed [63:0]  a64, b64;
	logic [31:0]         abs_a, abs_b;
	logic [63:0]         pmag, pround;
	fpa_pkg::res_t       res_c;
	fpa_pkg::val_t       vr;

	assign a64 = 64'(a_s1);
	assign b64 = 64'(b_s1);
	assign abs_a = a_s1[31] ? (~a_s1 + 32'd1) : a_s1;
	assign abs_b = b_s1[31] ? (~b_s1 + 32'd1) : b_s1;
	assign pmag = prod_s1[63] ? (~prod_s1 + 64'd1) : prod_s1;
	assign pround = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

	// Results of every command except a divide by a nonzero divisor.
	always_comb begin
		res_c = '0;
		vr = '0;
		res_c.neg = a_s1[31] ^ b_s1[31];
		unique case (cmd_s1)
			fpa_pkg::CMD_ADD:      vr = fpa_pkg::clamp_s64(a64 + b64);
			fpa_pkg::CMD_SUB:      vr = fpa_pkg::clamp_s64(a64 - b64);
			fpa_pkg::CMD_MUL:      vr = fpa_pkg::from_mag(prod_s1[63], pround);
			fpa_pkg::CMD_DIV: begin
				res_c.dz = (b_s1 == 32'sd0);
				res_c.is_div = (b_s1 != 32'sd0);
			end
			fpa_pkg::CMD_EQ:       res_c.cmp = (a_s1 == b_s1);
			fpa_pkg::CMD_NE:       res_c.cmp = (a_s1 != b_s1);
			fpa_pkg::CMD_LT:       res_c.cmp = (a_s1 < b_s1);
			fpa_pkg::CMD_GT:       res_c.cmp = (a_s1 > b_s1);
			fpa_pkg::CMD_LE:       res_c.cmp = (a_s1 <= b_s1);
			fpa_pkg::CMD_GE:       res_c.cmp = (a_s1 >= b_s1);
			fpa_pkg::CMD_MIN:      vr.value = (a_s1 <= b_s1) ? a_s1 : b_s1;
			fpa_pkg::CMD_MAX:      vr.value = (a_s1 >= b_s1) ? a_s1 : b_s1;
			fpa_pkg::CMD_INC:      vr = fpa_pkg::clamp_s64(a64 + 64'sd1);
			fpa_pkg::CMD_DEC:      vr = fpa_pkg::clamp_s64(a64 - 64'sd1);
			fpa_pkg::CMD_FROM_INT: vr = fpa_pkg::clamp_s64(a64 <<< FRAC_BITS);
			fpa_pkg::CMD_TO_INT:   vr = fpa_pkg::from_mag(a_s1[31],
				64'(abs_a) >> FRAC_BITS);
		endcase
		res_c.value = vr.value;
		res_c.sat = vr.sat;
	end

	// Stage two holds the results and the divider's starting operands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			res_s2 <= res_c;
			nq_s2 <= {abs_a, {FRAC_BITS{1'b0}}};
			d_s2 <= abs_b;
		end
	end

	assign out_valid = v_s2;
	assign out_res = res_s2;
	assign out_nq = nq_s2;
	assign out_d = d_s2;

endmodule

FILE: hdl/fpa_div_cell.sv
// One restoring-division cell: develops one quotient bit per beat and hands
// the partial remainder to its neighbor. Uses fpa_pkg.
module fpa_div_cell #(
	parameter int NQ = 32 + fpa_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fpa_pkg::res_t  in_res,
	input  logic [NQ-1:0]  in_nq,
	input  logic [31:0]    in_rem,
	input  logic [31:0]    in_d,
	output logic           out_valid,
	input  logic           out_ready,
	output fpa_pkg::res_t  out_res,
	output logic [NQ-1:0]  out_nq,
	output logic [31:0]    out_rem,
	output logic [31:0]    out_d
);

	logic           valid_q;
	fpa_pkg::res_t  res_q;
	logic [NQ-1:0]  nq_q;
	logic [31:0]    rem_q, d_q;
	logic           en;
	logic [32:0]    trial, diff;
	logic           ge;

	assign en = !valid_q || out_ready;
	assign in_ready = en;

	// Shift in the next numerator bit and subtract the divisor if it fits.
	assign trial = {in_rem, in_nq[NQ-1]};
	assign diff = trial - {1'b0, in_d};
	assign ge = (trial >= {1'b0, in_d});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			res_q <= in_res;
			nq_q <= {in_nq[NQ-2:0], ge};
			rem_q <= ge ? diff[31:0] : trial[31:0];
			d_q <= in_d;
		end
	end

	assign out_valid = valid_q;
	assign out_res = res_q;
	assign out_nq = nq_q;
	assign out_rem = rem_q;
	assign out_d = d_q;

endmodule

FILE: hdl/fpa_back.sv
// Output stage of the fixed-point ALU: rounds and clamps the quotient and
// holds the result beat for the receiver. Uses fpa_pkg.
module fpa_back #(
	parameter int NQ = 32 + fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fpa_pkg::res_t       in_res,
	input  logic [NQ-1:0]       in_nq,
	input  logic [31:0]         in_rem,
	input  logic [31:0]         in_d,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  result_value,
	output logic                compare_true,
	output logic                saturated,
	output logic                divide_by_zero
);

	logic           valid_q;
	logic           en;
	logic           round_up;
	logic [NQ:0]    qm;
	fpa_pkg::val_t  qv;

	assign en = !valid_q || !out_stall;
	assign in_ready = en;

	// Round half away from zero: bump when twice the remainder reaches d.
	assign round_up = ({in_rem, 1'b0} >= {1'b0, in_d});
	assign qm = {1'b0, in_nq} + (NQ+1)'(round_up);
	assign qv = fpa_pkg::from_mag(in_res.neg, 64'(qm));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			result_value <= in_res.is_div ? qv.value : in_res.value;
			saturated <= in_res.is_div ? qv.sat : in_res.sat;
			compare_true <= in_res.cmp;
			divide_by_zero <= in_res.dz;
		end
	end

	assign out_valid = valid_q;

endmodule
